/* sv/mlsch_pkg.sv */
// Shared types and constants for the multilevel SRTF/round-robin scheduler.
package mlsch_pkg;

  parameter int QueueDepthDef = 16;

  localparam logic [11:0] ThresholdReset = 12'd5;
  localparam logic [7:0]  SliceReset     = 8'd2;

  localparam logic OpArrival = 1'b0;
  localparam logic OpTick    = 1'b1;

  localparam logic CfgThreshold = 1'b0;
  localparam logic CfgSlice     = 1'b1;

  localparam logic [1:0] RqIdle  = 2'd0;
  localparam logic [1:0] RqInter = 2'd1;
  localparam logic [1:0] RqBatch = 2'd2;

  typedef struct packed {
    logic [7:0]  id;
    logic [11:0] remaining;
    logic [11:0] executed;
    logic [15:0] wait_cnt;
  } entry_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  task_id;
    logic [11:0] burst_time;
  } item_t;

  typedef struct packed {
    logic        arrival_rejected;
    logic [1:0]  running_queue;
    logic [7:0]  running_id;
    logic        finished;
    logic [7:0]  finished_id;
    logic [15:0] finished_wait;
    logic [15:0] finished_turnaround;
    logic [31:0] total_turnaround;
    logic [31:0] total_wait;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_INS0,
    ST_ITICK,
    ST_BWALK,
    ST_SUM
  } state_e;

endpackage

/* sv/mlsch_queue_mem.sv */
// Task entry memory: one write port, one registered read port.
module mlsch_queue_mem #(
  parameter int DEPTH = mlsch_pkg::QueueDepthDef,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  mlsch_pkg::entry_t    wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output mlsch_pkg::entry_t    rdata_o
);

  mlsch_pkg::entry_t mem [DEPTH];
  mlsch_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mlsch_entry_unit.sv */
// Shared entry update unit: run one unit or age one wait tick.
module mlsch_entry_unit (
  input  mlsch_pkg::entry_t entry_i,
  input  logic              run_i,
  output mlsch_pkg::entry_t entry_o,
  output logic              ran_o,
  output logic              done_o,
  output logic [15:0]       turnaround_o
);

  logic [16:0] tt_sum;

  always_comb begin
    entry_o = entry_i;
    ran_o   = 1'b0;
    if (run_i) begin
      if (entry_i.remaining != 12'd0) begin
        entry_o.remaining = entry_i.remaining - 12'd1;
        entry_o.executed  = entry_i.executed + 12'd1;
        ran_o             = 1'b1;
      end
    end else if (entry_i.wait_cnt != 16'hFFFF) begin
      entry_o.wait_cnt = entry_i.wait_cnt + 16'd1;
    end
    done_o       = run_i && (entry_o.remaining == 12'd0);
    tt_sum       = 17'(entry_o.executed) + 17'(entry_o.wait_cnt);
    turnaround_o = tt_sum[16] ? 16'hFFFF : tt_sum[15:0];
  end

endmodule

/* sv/multilevel_srtf_rr_scheduler_core.sv */
// Two-level scheduler top: sorted interactive queue and round-robin batch queue.
// Arrival: an empty or full queue or a batch append goes straight to ST_SUM; a sorted
// insert moves one entry per cycle through the interactive memory port.
// Tick: walks the interactive then the batch queue; each queued entry is run or aged by
// the shared entry unit, one per cycle. done_o pulses one cycle; the receiver cannot stall.
// Reset empties both queues, clears sums and slice, loads register defaults.
module multilevel_srtf_rr_scheduler_core #(
  parameter int QUEUE_DEPTH = mlsch_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mlsch_pkg::item_t    item_i,
  output logic                busy_o,
  output logic                done_o,
  output mlsch_pkg::result_t  result_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [11:0]         cfg_data_i
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = CW + 1;

  mlsch_pkg::state_e  state_q, state_d;
  logic [11:0]        thr_q;
  logic [7:0]         slice_cfg_q;
  logic [CW-1:0]      icnt_q, icnt_d, bcnt_q, bcnt_d;
  logic [AW-1:0]      bhead_q, bhead_d;
  logic [7:0]         slice_used_q, slice_used_d;
  logic [31:0]        tsum_q, tsum_d, wsum_q, wsum_d;
  logic [CW-1:0]      idx_q, idx_d, len_q, len_d;
  logic [AW-1:0]      slot_q, slot_d;
  mlsch_pkg::entry_t  task_q, task_d;
  logic               fin_q, fin_d, bserve_q, bserve_d;
  mlsch_pkg::result_t res_q, res_d;
  logic               valid_q, valid_d;

  logic               i_we, b_we;
  logic [AW-1:0]      i_waddr, i_raddr, b_waddr, b_raddr;
  mlsch_pkg::entry_t  i_wdata, b_wdata, i_rdata, b_rdata;

  mlsch_pkg::entry_t  eu_in, eu_out;
  logic               eu_run, eu_ran, eu_done;
  logic [15:0]        eu_tt;

  logic [TW-1:0]      tail_sum;
  logic [AW-1:0]      tail_slot, slot_next, head_next;
  logic [7:0]         slice_new;
  logic               fin_now;

  mlsch_queue_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_imem (
    .clk_i, .we_i(i_we), .waddr_i(i_waddr), .wdata_i(i_wdata),
    .raddr_i(i_raddr), .rdata_o(i_rdata)
  );

  mlsch_queue_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_bmem (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  mlsch_entry_unit u_eu (
    .entry_i(eu_in), .run_i(eu_run), .entry_o(eu_out),
    .ran_o(eu_ran), .done_o(eu_done), .turnaround_o(eu_tt)
  );

  assign tail_sum  = TW'(bhead_q) + TW'(bcnt_q);
  assign tail_slot = (tail_sum >= TW'(QUEUE_DEPTH)) ? AW'(tail_sum - TW'(QUEUE_DEPTH))
                                                    : AW'(tail_sum);
  assign slot_next = (slot_q == AW'(QUEUE_DEPTH - 1)) ? '0 : slot_q + AW'(1);
  assign head_next = (bhead_q == AW'(QUEUE_DEPTH - 1)) ? '0 : bhead_q + AW'(1);
  assign slice_new = eu_ran ? slice_used_q + 8'd1 : slice_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= mlsch_pkg::ThresholdReset;
      slice_cfg_q <= mlsch_pkg::SliceReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlsch_pkg::CfgThreshold: thr_q       <= cfg_data_i;
        mlsch_pkg::CfgSlice:     slice_cfg_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mlsch_pkg::ST_IDLE;
      icnt_q       <= '0;
      bcnt_q       <= '0;
      bhead_q      <= '0;
      slice_used_q <= '0;
      tsum_q       <= '0;
      wsum_q       <= '0;
      fin_q        <= 1'b0;
      bserve_q     <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      icnt_q       <= icnt_d;
      bcnt_q       <= bcnt_d;
      bhead_q      <= bhead_d;
      slice_used_q <= slice_used_d;
      tsum_q       <= tsum_d;
      wsum_q       <= wsum_d;
      fin_q        <= fin_d;
      bserve_q     <= bserve_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    len_q  <= len_d;
    slot_q <= slot_d;
    task_q <= task_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d      = state_q;
    icnt_d       = icnt_q;
    bcnt_d       = bcnt_q;
    bhead_d      = bhead_q;
    slice_used_d = slice_used_q;
    tsum_d       = tsum_q;
    wsum_d       = wsum_q;
    idx_d        = idx_q;
    len_d        = len_q;
    slot_d       = slot_q;
    task_d       = task_q;
    fin_d        = fin_q;
    bserve_d     = bserve_q;
    res_d        = res_q;
    valid_d      = 1'b0;
    i_we         = 1'b0;
    i_waddr      = '0;
    i_wdata      = task_q;
    i_raddr      = '0;
    b_we         = 1'b0;
    b_waddr      = slot_q;
    b_wdata      = eu_out;
    b_raddr      = slot_next;
    eu_in        = i_rdata;
    eu_run       = 1'b0;
    fin_now      = fin_q;

    case (state_q)
      mlsch_pkg::ST_IDLE: begin
        if (start_i) begin
          res_d  = '0;
          fin_d  = 1'b0;
          task_d = '{id: item_i.task_id, remaining: item_i.burst_time,
                     executed: 12'd0, wait_cnt: 16'd0};
          if (item_i.operation == mlsch_pkg::OpArrival) begin
            state_d = mlsch_pkg::ST_SUM;
            if (item_i.burst_time < thr_q) begin
              if (icnt_q == CW'(QUEUE_DEPTH)) begin
                res_d.arrival_rejected = 1'b1;
              end else if (icnt_q == '0) begin
                i_we    = 1'b1;
                i_waddr = '0;
                i_wdata = task_d;
                icnt_d  = icnt_q + CW'(1);
              end else begin
                i_raddr = AW'(icnt_q - CW'(1));
                idx_d   = icnt_q - CW'(1);
                state_d = mlsch_pkg::ST_INS;
              end
            end else if (bcnt_q == CW'(QUEUE_DEPTH)) begin
              res_d.arrival_rejected = 1'b1;
            end else begin
              b_we    = 1'b1;
              b_waddr = tail_slot;
              b_wdata = task_d;
              bcnt_d  = bcnt_q + CW'(1);
            end
          end else if (icnt_q != '0) begin
            i_raddr             = '0;
            idx_d               = '0;
            len_d               = icnt_q;
            res_d.running_queue = mlsch_pkg::RqInter;
            state_d             = mlsch_pkg::ST_ITICK;
          end else if (bcnt_q != '0) begin
            b_raddr             = bhead_q;
            slot_d              = bhead_q;
            idx_d               = '0;
            len_d               = bcnt_q;
            bserve_d            = 1'b1;
            res_d.running_queue = mlsch_pkg::RqBatch;
            state_d             = mlsch_pkg::ST_BWALK;
          end else begin
            state_d = mlsch_pkg::ST_SUM;
          end
        end
      end

      mlsch_pkg::ST_INS: begin
        i_we    = 1'b1;
        i_waddr = AW'(idx_q + CW'(1));
        if (i_rdata.remaining <= task_q.remaining) begin
          i_wdata = task_q;
          icnt_d  = icnt_q + CW'(1);
          state_d = mlsch_pkg::ST_SUM;
        end else begin
          i_wdata = i_rdata;
          if (idx_q == '0) begin
            state_d = mlsch_pkg::ST_INS0;
          end else begin
            idx_d   = idx_q - CW'(1);
            i_raddr = AW'(idx_q - CW'(1));
          end
        end
      end

      mlsch_pkg::ST_INS0: begin
        i_we    = 1'b1;
        i_waddr = '0;
        i_wdata = task_q;
        icnt_d  = icnt_q + CW'(1);
        state_d = mlsch_pkg::ST_SUM;
      end

      mlsch_pkg::ST_ITICK: begin
        eu_in   = i_rdata;
        eu_run  = (idx_q == '0);
        i_raddr = AW'(idx_q + CW'(1));
        i_wdata = eu_out;
        if (idx_q == '0) begin
          res_d.running_id = i_rdata.id;
          fin_now          = eu_done;
          if (eu_done) begin
            fin_d                     = 1'b1;
            res_d.finished            = 1'b1;
            res_d.finished_id         = eu_out.id;
            res_d.finished_wait       = eu_out.wait_cnt;
            res_d.finished_turnaround = eu_tt;
          end else begin
            i_we    = 1'b1;
            i_waddr = '0;
          end
        end else begin
          i_we    = 1'b1;
          i_waddr = fin_q ? AW'(idx_q - CW'(1)) : AW'(idx_q);
        end
        if (idx_q == len_q - CW'(1)) begin
          if (fin_now) begin
            icnt_d = icnt_q - CW'(1);
          end
          if (bcnt_q != '0) begin
            b_raddr  = bhead_q;
            slot_d   = bhead_q;
            idx_d    = '0;
            len_d    = bcnt_q;
            bserve_d = 1'b0;
            state_d  = mlsch_pkg::ST_BWALK;
          end else begin
            state_d = mlsch_pkg::ST_SUM;
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end

      mlsch_pkg::ST_BWALK: begin
        eu_in  = b_rdata;
        eu_run = bserve_q && (idx_q == '0);
        if (eu_run) begin
          res_d.running_id = b_rdata.id;
          if (eu_done) begin
            fin_d                     = 1'b1;
            res_d.finished            = 1'b1;
            res_d.finished_id         = eu_out.id;
            res_d.finished_wait       = eu_out.wait_cnt;
            res_d.finished_turnaround = eu_tt;
            bhead_d                   = head_next;
            bcnt_d                    = bcnt_q - CW'(1);
            slice_used_d              = '0;
          end else if (slice_new >= slice_cfg_q) begin
            b_we         = 1'b1;
            b_waddr      = tail_slot;
            bhead_d      = head_next;
            slice_used_d = '0;
          end else begin
            b_we         = 1'b1;
            slice_used_d = slice_new;
          end
        end else begin
          b_we = 1'b1;
        end
        if (idx_q == len_q - CW'(1)) begin
          state_d = mlsch_pkg::ST_SUM;
        end else begin
          idx_d  = idx_q + CW'(1);
          slot_d = slot_next;
        end
      end

      mlsch_pkg::ST_SUM: begin
        if (fin_q) begin
          tsum_d = tsum_q + 32'(res_q.finished_turnaround);
          wsum_d = wsum_q + 32'(res_q.finished_wait);
        end
        res_d.total_turnaround = tsum_d;
        res_d.total_wait       = wsum_d;
        valid_d                = 1'b1;
        state_d                = mlsch_pkg::ST_IDLE;
      end

      default: begin
        state_d = mlsch_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o   = (state_q != mlsch_pkg::ST_IDLE);
  assign done_o   = valid_q;
  assign result_o = res_q;

endmodule

/* sim/tb_multilevel_srtf_rr_scheduler_core.sv */
// Self-checking testbench for the two-level SRTF/round-robin scheduler core.
module tb_multilevel_srtf_rr_scheduler_core;

  localparam int Depth     = mlsch_pkg::QueueDepthDef;
  localparam int CycleCap  = 900000;
  localparam int DrainWait = 60;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  mlsch_pkg::item_t    item_i = '0;
  logic                busy_o, done_o;
  mlsch_pkg::result_t  result_o;
  logic                cfg_we_i = 1'b0;
  logic                cfg_idx_i = mlsch_pkg::CfgThreshold;
  logic [11:0]         cfg_data_i = '0;

  multilevel_srtf_rr_scheduler_core dut (.*);

  always #1 clk_i = ~clk_i;

  // scheduler shadow state
  mlsch_pkg::entry_t inter_q[$];
  mlsch_pkg::entry_t batch_q[$];
  logic [11:0] thresh;
  logic [7:0]  slice_len;
  logic [7:0]  slice_cnt;
  logic [31:0] tat_sum, wait_sum;

  mlsch_pkg::item_t   pending_items[$];
  mlsch_pkg::result_t expected_results[$];
  int      errors = 0;
  int      cycles = 0;
  int      sched_ticks = 0;
  int      finishes = 0;
  int      rejects = 0;
  int      send_idle = 24;
  bit      taken = 1'b0;

  function automatic logic [15:0] age(logic [15:0] w);
    return (w == 16'hFFFF) ? w : w + 16'd1;
  endfunction

  function automatic void retire(mlsch_pkg::entry_t e, ref mlsch_pkg::result_t r);
    logic [16:0] tt;
    tt = 17'(e.executed) + 17'(e.wait_cnt);
    if (tt > 17'hFFFF) tt = 17'hFFFF;
    tat_sum += 32'(tt[15:0]);
    wait_sum += 32'(e.wait_cnt);
    r.finished = 1'b1;
    r.finished_id = e.id;
    r.finished_wait = e.wait_cnt;
    r.finished_turnaround = tt[15:0];
    finishes++;
  endfunction

  function automatic mlsch_pkg::result_t schedule_step(mlsch_pkg::item_t it);
    mlsch_pkg::result_t r;
    mlsch_pkg::entry_t  e;
    int      pos;
    logic [7:0] lim;
    r = '0;
    if (it.operation == mlsch_pkg::OpArrival) begin
      e = '{id: it.task_id, remaining: it.burst_time, executed: '0, wait_cnt: '0};
      if (it.burst_time < thresh) begin
        if (inter_q.size() >= Depth) r.arrival_rejected = 1'b1;
        else begin
          pos = 0;
          while (pos < inter_q.size() && inter_q[pos].remaining <= e.remaining) pos++;
          inter_q.insert(pos, e);
        end
      end else begin
        if (batch_q.size() >= Depth) r.arrival_rejected = 1'b1;
        else batch_q.push_back(e);
      end
      if (r.arrival_rejected) rejects++;
    end else begin
      sched_ticks++;
      if (inter_q.size() > 0) begin
        for (int i = 1; i < inter_q.size(); i++) inter_q[i].wait_cnt = age(inter_q[i].wait_cnt);
        foreach (batch_q[i]) batch_q[i].wait_cnt = age(batch_q[i].wait_cnt);
        r.running_queue = mlsch_pkg::RqInter;
        r.running_id = inter_q[0].id;
        if (inter_q[0].remaining != 0) begin
          inter_q[0].remaining--;
          inter_q[0].executed++;
        end
        if (inter_q[0].remaining == 0) begin
          retire(inter_q[0], r);
          void'(inter_q.pop_front());
        end
      end else if (batch_q.size() > 0) begin
        for (int i = 1; i < batch_q.size(); i++) batch_q[i].wait_cnt = age(batch_q[i].wait_cnt);
        r.running_queue = mlsch_pkg::RqBatch;
        r.running_id = batch_q[0].id;
        if (batch_q[0].remaining != 0) begin
          batch_q[0].remaining--;
          batch_q[0].executed++;
          slice_cnt++;
        end
        lim = slice_len;
        if (batch_q[0].remaining == 0) begin
          retire(batch_q[0], r);
          void'(batch_q.pop_front());
          slice_cnt = '0;
        end else if (slice_cnt >= lim) begin
          batch_q.push_back(batch_q.pop_front());
          slice_cnt = '0;
        end
      end
    end
    r.total_turnaround = tat_sum;
    r.total_wait = wait_sum;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", field, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!start_i || taken) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
          item_i <= pending_items.pop_front();
          start_i <= 1'b1;
        end else begin
          start_i <= 1'b0;
          item_i <= '0;
        end
      end
    end
  end

  // acceptance: predict on the edge where the transaction is taken
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    taken <= rst_ni && start_i && !busy_o;
    if (rst_ni && start_i && !busy_o)
      expected_results.push_back(schedule_step(item_i));
    if (rst_ni && done_o) begin
      mlsch_pkg::result_t w;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 32'(done_o), 32'd0);
      end else begin
        w = expected_results.pop_front();
        if (result_o.arrival_rejected !== w.arrival_rejected)
          report_mismatch("arrival_rejected", 32'(result_o.arrival_rejected),
                          32'(w.arrival_rejected));
        if (result_o.running_queue !== w.running_queue)
          report_mismatch("running_queue", 32'(result_o.running_queue),
                          32'(w.running_queue));
        if (result_o.running_id !== w.running_id)
          report_mismatch("running_id", 32'(result_o.running_id), 32'(w.running_id));
        if (result_o.finished !== w.finished)
          report_mismatch("finished", 32'(result_o.finished), 32'(w.finished));
        if (result_o.finished_id !== w.finished_id)
          report_mismatch("finished_id", 32'(result_o.finished_id), 32'(w.finished_id));
        if (result_o.finished_wait !== w.finished_wait)
          report_mismatch("finished_wait", 32'(result_o.finished_wait),
                          32'(w.finished_wait));
        if (result_o.finished_turnaround !== w.finished_turnaround)
          report_mismatch("finished_turnaround", 32'(result_o.finished_turnaround),
                          32'(w.finished_turnaround));
        if (result_o.total_turnaround !== w.total_turnaround)
          report_mismatch("total_turnaround", result_o.total_turnaround, w.total_turnaround);
        if (result_o.total_wait !== w.total_wait)
          report_mismatch("total_wait", result_o.total_wait, w.total_wait);
      end
    end
    if (cycles >= CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("[multilevel_srtf_rr_scheduler_core] ERROR");
      $finish;
    end
  end

  task automatic add_item(logic op, logic [7:0] id, logic [11:0] burst);
    mlsch_pkg::item_t it;
    it.operation = op;
    it.task_id = id;
    it.burst_time = burst;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_results.size() > 0 || start_i)
      @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mlsch_pkg::CfgThreshold) thresh = val;
    else slice_len = (val[7:0] == 8'd0) ? 8'd1 : val[7:0];
  endtask

  // mostly bursts of arrivals followed by runs of ticks, plus noise
  task automatic random_phase(int n);
    int k, b;
    k = 0;
    while (k < n) begin
      b = $urandom_range(6, 1);
      for (int j = 0; j < b; j++) begin
        add_item(mlsch_pkg::OpArrival, 8'($urandom),
                 ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(12)));
        k++;
      end
      b = $urandom_range(40, 2);
      for (int j = 0; j < b; j++) begin
        add_item(($urandom_range(9) == 0) ? mlsch_pkg::OpArrival : mlsch_pkg::OpTick,
                 8'($urandom), 12'($urandom_range(8)));
        k++;
      end
    end
  endtask

  initial begin
    thresh = mlsch_pkg::ThresholdReset;
    slice_len = mlsch_pkg::SliceReset;
    slice_cnt = '0;
    tat_sum = '0;
    wait_sum = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle tick, zero bursts, ties, extremes, preemption, full queues
    add_item(mlsch_pkg::OpTick, 8'hFF, 12'hFFF);
    add_item(mlsch_pkg::OpArrival, 8'h01, 12'd0);
    add_item(mlsch_pkg::OpArrival, 8'h02, 12'd3);
    add_item(mlsch_pkg::OpArrival, 8'h03, 12'd3);
    add_item(mlsch_pkg::OpArrival, 8'h04, 12'd1);
    add_item(mlsch_pkg::OpArrival, 8'hFF, 12'd5);
    add_item(mlsch_pkg::OpArrival, 8'h00, 12'd4);
    add_item(mlsch_pkg::OpTick, 8'h00, 12'd0);
    add_item(mlsch_pkg::OpTick, 8'h00, 12'd0);
    add_item(mlsch_pkg::OpTick, 8'h00, 12'd0);
    add_item(mlsch_pkg::OpTick, 8'h00, 12'd0);
    add_item(mlsch_pkg::OpTick, 8'h00, 12'd0);
    add_item(mlsch_pkg::OpArrival, 8'hAA, 12'd2);
    for (int i = 0; i < 10; i++) add_item(mlsch_pkg::OpTick, 8'h55, 12'hAAA);
    wait_idle();

    for (int i = 0; i < 18; i++) add_item(mlsch_pkg::OpArrival, 8'(i), 12'd1);
    for (int i = 0; i < 18; i++) add_item(mlsch_pkg::OpArrival, 8'h80 | 8'(i), 12'd6);
    for (int i = 0; i < 80; i++) add_item(mlsch_pkg::OpTick, 8'h00, 12'd0);
    wait_idle();

    // wide threshold and slice extremes
    write_cfg(mlsch_pkg::CfgThreshold, 12'hFFF);
    write_cfg(mlsch_pkg::CfgSlice, 12'h0FF);
    add_item(mlsch_pkg::OpArrival, 8'h11, 12'hFFE);
    add_item(mlsch_pkg::OpArrival, 8'h12, 12'hFFF);
    wait_idle();

    write_cfg(mlsch_pkg::CfgThreshold, 12'd0);
    write_cfg(mlsch_pkg::CfgSlice, 12'd0);
    random_phase(260);
    wait_idle();

    send_idle = 81;
    write_cfg(mlsch_pkg::CfgThreshold, 12'd4);
    write_cfg(mlsch_pkg::CfgSlice, 12'd3);
    random_phase(220);
    wait_idle();

    send_idle = 0;
    write_cfg(mlsch_pkg::CfgThreshold, 12'd7);
    write_cfg(mlsch_pkg::CfgSlice, 12'd1);
    random_phase(220);
    wait_idle();

    $display("covered %0d ticks, %0d completions, %0d rejected arrivals",
             sched_ticks, finishes, rejects);
    if (errors == 0) begin
      $display("[multilevel_srtf_rr_scheduler_core] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[multilevel_srtf_rr_scheduler_core] ERROR");
    end
    $finish;
  end

endmodule
